### rtl/core/mlbcm_pkg.sv
`default_nettype none

package mlbcm_pkg;

  // Number of light cells in the chain.
  localparam int unsigned LIGHTS = 8;

  // Width of the settle counter and of the active light count.
  localparam int unsigned CNT_W = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
  localparam int unsigned ACT_W = $clog2(LIGHTS + 1);

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] light_count;
    logic [2:0] light_index;
    logic [7:0] light_color;
    logic [7:0] on_time;
    logic [7:0] off_time;
    logic [7:0] phase_ticks;
  } mlbcm_in_t;

  // Output transaction.
  typedef struct packed {
    logic [7:0] red_pattern;
    logic [7:0] green_pattern;
    logic [7:0] blue_pattern;
    logic [7:0] lit_lights;
  } mlbcm_out_t;

  // Saturated colour sums handed along the cell chain.
  typedef struct packed {
    logic [2:0] red;
    logic [2:0] green;
    logic [1:0] blue;
  } mlbcm_sum_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;
    logic step;
    logic active;
  } mlbcm_ctrl_t;

  // Data written into a cell by a load.
  typedef struct packed {
    logic [7:0] color;
    logic [7:0] on_time;
    logic [7:0] off_time;
    logic [7:0] phase;
  } mlbcm_load_t;

  // PWM pattern for a red or green sum.
  function automatic logic [7:0] rg_pattern(input logic [2:0] level);
    logic [7:0] pat;
    case (level)
      3'd0:    pat = 8'h00;
      3'd1:    pat = 8'h01;
      3'd2:    pat = 8'h11;
      3'd3:    pat = 8'h29;
      3'd4:    pat = 8'h55;
      3'd5:    pat = 8'h75;
      3'd6:    pat = 8'h77;
      default: pat = 8'hEF;
    endcase
    return pat;
  endfunction

  // PWM pattern for a blue sum.
  function automatic logic [7:0] b_pattern(input logic [1:0] level);
    logic [7:0] pat;
    case (level)
      2'd0:    pat = 8'h00;
      2'd1:    pat = 8'h11;
      2'd2:    pat = 8'h55;
      default: pat = 8'hEF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mlbcm_cell.sv
`default_nettype none

module mlbcm_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mlbcm_pkg::mlbcm_ctrl_t ctrl_i,
  input  wire mlbcm_pkg::mlbcm_load_t load_i,
  input  wire mlbcm_pkg::mlbcm_sum_t  sum_i,
  output      mlbcm_pkg::mlbcm_sum_t  sum_o,
  output      logic                  lit_o,
  output      logic                  busy_o
);
  import mlbcm_pkg::*;

  logic [7:0] color_q, color_d;
  logic [7:0] on_q, on_d;
  logic [7:0] off_q, off_d;
  logic [7:0] cd_q, cd_d;
  logic [7:0] phase_q, phase_d;
  logic       lit_q, lit_d;
  logic       busy_q, busy_d;
  mlbcm_sum_t sum_q, sum_d;

  logic [8:0] period;
  logic [8:0] phase_ext;
  logic       contrib;
  logic [3:0] red_sum;
  logic [3:0] green_sum;
  logic [2:0] blue_sum;

  // A stored countdown of zero stands for a full period of 256.
  assign period    = (cd_q == 8'd0) ? 9'd256 : {1'b0, cd_q};
  assign phase_ext = {1'b0, phase_q};

  // Light state: load, one step of the phase skip per cycle, or a tick.
  always_comb begin
    color_d = color_q;
    on_d    = on_q;
    off_d   = off_q;
    cd_d    = cd_q;
    phase_d = phase_q;
    lit_d   = lit_q;
    busy_d  = busy_q;
    if (ctrl_i.load) begin
      color_d = load_i.color;
      on_d    = load_i.on_time;
      off_d   = load_i.off_time;
      cd_d    = load_i.on_time;
      phase_d = load_i.phase;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (phase_q == 8'd0) begin
        busy_d = 1'b0;
      end else if (phase_ext < period) begin
        cd_d   = 8'(period - phase_ext);
        busy_d = 1'b0;
      end else begin
        phase_d = 8'(phase_ext - period);
        lit_d   = !lit_q;
        cd_d    = lit_q ? off_q : on_q;
      end
    end else if (ctrl_i.step && ctrl_i.active) begin
      if (cd_q == 8'd1) begin
        lit_d = !lit_q;
        cd_d  = lit_q ? off_q : on_q;
      end else begin
        cd_d = cd_q - 8'd1;
      end
    end
  end

  // Add this light's colour to the sums from the previous cell.
  assign contrib   = ctrl_i.active && lit_q;
  assign red_sum   = {1'b0, sum_i.red} + (contrib ? {1'b0, color_q[7:5]} : 4'd0);
  assign green_sum = {1'b0, sum_i.green} + (contrib ? {1'b0, color_q[4:2]} : 4'd0);
  assign blue_sum  = {1'b0, sum_i.blue} + (contrib ? {1'b0, color_q[1:0]} : 3'd0);

  always_comb begin
    sum_d.red   = red_sum[3] ? 3'd7 : red_sum[2:0];
    sum_d.green = green_sum[3] ? 3'd7 : green_sum[2:0];
    sum_d.blue  = blue_sum[2] ? 2'd3 : blue_sum[1:0];
  end

  // Light parameters and countdown.
  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    on_q    <= on_d;
    off_q   <= off_d;
    cd_q    <= cd_d;
    phase_q <= phase_d;
  end

  // Control state and the chain register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q  <= 1'b1;
      busy_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      lit_q  <= lit_d;
      busy_q <= busy_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign lit_o  = lit_q;
  assign busy_o = busy_q;

endmodule

`default_nettype wire

### rtl/core/multi_light_blink_color_mixer.sv
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_data_i  (mlbcm_in_t)
// out      output     out_valid_o / out_stall_i  out_data_o (mlbcm_out_t)
//
// A start transaction sets the active count and the sequencer stays idle.
// During a tick the colour sums travel one cell per cycle along the chain
// of light cells. A load makes the addressed cell skip its phase one on/off
// period per step while the sequencer waits; the phase skip runs in the cell.
// Reset sets every on bit and clears the active count; no clearing pass.
// A tick waits at its end while the output register holds an untaken result.

module multi_light_blink_color_mixer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire mlbcm_pkg::mlbcm_in_t  in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      mlbcm_pkg::mlbcm_out_t out_data_o
);
  import mlbcm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIGHTS - 1);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACT_W-1:0] active_q, active_d;
  logic             out_valid_q, out_valid_d;
  mlbcm_out_t       out_q, out_d;

  logic               accept;
  logic               tick_done;
  logic               any_busy;
  logic [4:0]         count_ext;
  logic [LIGHTS-1:0]  busy;
  logic [LIGHTS-1:0]  lit;
  logic [LIGHTS-1:0]  load_sel;
  logic [7:0]         lit_vec;
  mlbcm_sum_t         chain [LIGHTS+1];
  mlbcm_load_t        load_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign any_busy   = |busy;
  assign tick_done  = (state_q == ST_SUM) && (cnt_q == CNT_LAST) &&
                      (!out_valid_q || !out_stall_i);

  assign load_data.color    = in_data_i.light_color;
  assign load_data.on_time  = in_data_i.on_time;
  assign load_data.off_time = in_data_i.off_time;
  assign load_data.phase    = in_data_i.phase_ticks;

  assign chain[0] = '0;

  // Row of light cells; the colour sums run from cell 0 upwards.
  for (genvar n = 0; n < LIGHTS; n++) begin : g_cell
    mlbcm_ctrl_t ctrl;

    if (n < 8) begin : g_addr
      assign load_sel[n] = accept && (in_data_i.opcode == OP_LOAD) &&
                           (in_data_i.light_index == 3'(n));
    end else begin : g_noaddr
      assign load_sel[n] = 1'b0;
    end

    assign ctrl.load   = load_sel[n];
    assign ctrl.step   = tick_done;
    assign ctrl.active = (ACT_W'(n) < active_q);

    mlbcm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .load_i (load_data),
      .sum_i  (chain[n]),
      .sum_o  (chain[n+1]),
      .lit_o  (lit[n]),
      .busy_o (busy[n])
    );
  end

  // On bits of the first eight lights; missing lights read as dark.
  for (genvar k = 0; k < 8; k++) begin : g_lit
    if (k < LIGHTS) begin : g_have
      assign lit_vec[k] = lit[k];
    end else begin : g_none
      assign lit_vec[k] = 1'b0;
    end
  end

  assign count_ext = {1'b0, in_data_i.light_count};

  // Sequencer over the three kinds of transaction.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.opcode)
            OP_START: begin
              if (count_ext > 5'(LIGHTS)) begin
                active_d = ACT_W'(LIGHTS);
              end else begin
                active_d = ACT_W'(count_ext);
              end
            end
            OP_LOAD: begin
              if (|load_sel) begin
                state_d = ST_LOAD;
              end
            end
            OP_TICK: begin
              state_d = ST_SUM;
              cnt_d   = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (!any_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (cnt_q != CNT_LAST) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (tick_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: filled at the end of a tick, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (tick_done) begin
      out_valid_d         = 1'b1;
      out_d.red_pattern   = rg_pattern(chain[LIGHTS].red);
      out_d.green_pattern = rg_pattern(chain[LIGHTS].green);
      out_d.blue_pattern  = b_pattern(chain[LIGHTS].blue);
      out_d.lit_lights    = lit_vec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A phase skip runs only while the sequencer waits for it.
  a_busy_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_busy |-> (state_q == ST_LOAD))
    else $error("cell busy outside a load");

  // A load addresses at most one cell.
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(load_sel))
    else $error("more than one cell loaded");

  // A result appears only at the end of the summing phase.
  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_SUM))
    else $error("result outside a tick");

  // The active count never exceeds the number of cells.
  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= ACT_W'(LIGHTS))
    else $error("active count out of range");

  // A finished load hands control back at once.
  a_load_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) && !any_busy |=> (state_q == ST_IDLE))
    else $error("load did not finish");

endmodule

`default_nettype wire
